// ----- design/slcp_pkg.sv -----
package slcp_pkg;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // prefix text, first character in the highest byte
   localparam logic [31:0] KEY_PREFIX  = 32'h4B_45_59_20;     // "KEY "
   localparam logic [39:0] CARD_PREFIX = 40'h43_41_52_44_20;  // "CARD "
   localparam int unsigned KEY_PREFIX_LEN  = 4;
   localparam int unsigned CARD_PREFIX_LEN = 5;
   localparam int unsigned CARD_ID_BYTES   = 4;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_CARD = 1'b1;

   localparam logic [1:0] RD_OFF_FIRST  = 2'd0;
   localparam logic [1:0] RD_OFF_SECOND = 2'd1;
   localparam logic [1:0] RD_OFF_SEP    = 2'd2;

   typedef struct packed {
      logic       store_wr;
      logic       fill_clr;
      logic       pos_key;
      logic       pos_card;
      logic       pos_inc;
      logic       rd_en;
      logic [1:0] rd_off;
      logic       c0_cap;
      logic       c1_cap;
      logic       card_step;
      logic       id_clr;
      logic       pend_load;
      logic       pend_clr;
      logic       out_key;
      logic       out_last;
      logic       out_empty;
      logic       out_card;
   } cmd_type;

   typedef struct packed {
      logic line_end;
      logic fill_nz;
      logic is_key;
      logic is_card;
      logic rd_end;
      logic pend_valid;
      logic out_busy;
   } status_type;

endpackage

// ----- design/slcp_dp.sv -----
module slcp_dp #(
   parameter int unsigned LINE_BUFFER_BYTES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_tdata,
   input  slcp_pkg::cmd_type    cmd,
   output slcp_pkg::status_type sts,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   localparam int unsigned IDX_W = $clog2(LINE_BUFFER_BYTES);
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(LINE_BUFFER_BYTES - 1);

   logic [7:0]       store_mem [LINE_BUFFER_BYTES];
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] pos_ff;
   logic             key_ok_ff;
   logic             card_ok_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_in_ff;
   logic [7:0]       c0_ff;
   logic [7:0]       c1_ff;
   logic [31:0]      id_ff;
   logic [7:0]       pend_ff;
   logic             pend_valid_ff;
   logic             rsp_valid_ff;
   logic             rsp_kind_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_pres_ff;
   logic [31:0]      rsp_id_ff;
   logic             rsp_last_ff;

   logic [CNT_W-1:0] rd_addr;
   logic [7:0]       rd_char;
   logic             key_match;
   logic             card_match;
   logic [7:0]       pair;
   logic             sep_space;

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] pair_value(input logic [7:0] c0, input logic [7:0] c1);
      logic [4:0] h0;
      logic [4:0] h1;
      logic [7:0] r;
      h0 = hex_val(c0);
      h1 = hex_val(c1);
      r  = 8'd0;
      if (c0 == slcp_pkg::CHAR_SPACE || c0 == slcp_pkg::CHAR_TAB ||
          c0 == slcp_pkg::CHAR_LF || c0 == slcp_pkg::CHAR_VT ||
          c0 == slcp_pkg::CHAR_FF || c0 == slcp_pkg::CHAR_CR) begin
         r = h1[4] ? {4'd0, h1[3:0]} : 8'd0;
      end else if (c0 == slcp_pkg::CHAR_PLUS) begin
         r = h1[4] ? {4'd0, h1[3:0]} : 8'd0;
      end else if (c0 == slcp_pkg::CHAR_MINUS) begin
         r = h1[4] ? 8'(8'd0 - {4'd0, h1[3:0]}) : 8'd0;
      end else if (h0[4]) begin
         r = h1[4] ? {h0[3:0], h1[3:0]} : {4'd0, h0[3:0]};
      end
      return r;
   endfunction

   // prefix flags are built as the first bytes arrive
   always_comb begin
      key_match  = 1'b0;
      card_match = 1'b0;
      for (int i = 0; i < 5; i++) begin
         if (fill_ff == CNT_W'(i)) begin
            if (i < 4) begin
               key_match = (req_tdata == slcp_pkg::KEY_PREFIX[8*(3-i) +: 8]);
            end
            card_match = (req_tdata == slcp_pkg::CARD_PREFIX[8*(4-i) +: 8]);
         end
      end
   end

   assign rd_addr   = pos_ff + CNT_W'(cmd.rd_off);
   assign rd_char   = rd_in_ff ? rd_data_ff : 8'd0;
   assign pair      = pair_value(c0_ff, c1_ff);
   assign sep_space = (rd_char == slcp_pkg::CHAR_SPACE);

   always_ff @(posedge clock) begin
      if (cmd.store_wr && fill_ff != FILL_MAX) begin
         store_mem[fill_ff[IDX_W-1:0]] <= req_tdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr[IDX_W-1:0]];
         rd_in_ff   <= (rd_addr < fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         key_ok_ff  <= 1'b0;
         card_ok_ff <= 1'b0;
      end else if (cmd.fill_clr) begin
         fill_ff <= '0;
      end else if (cmd.store_wr) begin
         if (fill_ff == FILL_MAX) begin
            fill_ff <= '0;
         end else begin
            fill_ff <= fill_ff + CNT_W'(1);
            if (fill_ff == '0) begin
               key_ok_ff  <= key_match;
               card_ok_ff <= card_match;
            end else begin
               key_ok_ff  <= key_ok_ff & (key_match | fill_ff >= CNT_W'(4));
               card_ok_ff <= card_ok_ff & (card_match | fill_ff >= CNT_W'(5));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pos_key) begin
         pos_ff <= CNT_W'(slcp_pkg::KEY_PREFIX_LEN);
      end else if (cmd.pos_card) begin
         pos_ff <= CNT_W'(slcp_pkg::CARD_PREFIX_LEN);
      end else if (cmd.pos_inc) begin
         pos_ff <= pos_ff + CNT_W'(1);
      end else if (cmd.card_step) begin
         pos_ff <= pos_ff + CNT_W'(2) + CNT_W'(sep_space);
      end
      if (cmd.c0_cap) begin
         c0_ff <= rd_char;
      end
      if (cmd.c1_cap) begin
         c1_ff <= rd_char;
      end
      if (cmd.id_clr) begin
         id_ff <= '0;
      end else if (cmd.card_step) begin
         id_ff <= {id_ff[23:0], pair};
      end
      if (cmd.pend_load) begin
         pend_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.pend_clr) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.pend_load) begin
         pend_valid_ff <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_key || cmd.out_empty || cmd.out_card) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_key) begin
         rsp_kind_ff <= slcp_pkg::KIND_KEY;
         rsp_char_ff <= pend_ff;
         rsp_pres_ff <= 1'b1;
         rsp_id_ff   <= '0;
         rsp_last_ff <= cmd.out_last;
      end else if (cmd.out_empty) begin
         rsp_kind_ff <= slcp_pkg::KIND_KEY;
         rsp_char_ff <= '0;
         rsp_pres_ff <= 1'b0;
         rsp_id_ff   <= '0;
         rsp_last_ff <= 1'b1;
      end else if (cmd.out_card) begin
         rsp_kind_ff <= slcp_pkg::KIND_CARD;
         rsp_char_ff <= '0;
         rsp_pres_ff <= 1'b0;
         rsp_id_ff   <= id_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_id_ff, rsp_char_ff};
   assign rsp_tuser  = {rsp_pres_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign sts.line_end   = (req_tdata == slcp_pkg::CHAR_LF) || (req_tdata == slcp_pkg::CHAR_CR);
   assign sts.fill_nz    = (fill_ff != '0);
   assign sts.is_key     = key_ok_ff && (fill_ff >= CNT_W'(slcp_pkg::KEY_PREFIX_LEN));
   assign sts.is_card    = card_ok_ff && (fill_ff >= CNT_W'(slcp_pkg::CARD_PREFIX_LEN));
   assign sts.rd_end     = !rd_in_ff || (rd_data_ff == slcp_pkg::CHAR_NUL);
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_busy   = rsp_valid_ff && !rsp_tready;

endmodule

// ----- design/slcp_ctrl.sv -----
module slcp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  slcp_pkg::status_type sts,
   output slcp_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_K_RD   = 4'd1;
   localparam logic [3:0] ST_K_EV   = 4'd2;
   localparam logic [3:0] ST_C_RD0  = 4'd3;
   localparam logic [3:0] ST_C_RD1  = 4'd4;
   localparam logic [3:0] ST_C_RD2  = 4'd5;
   localparam logic [3:0] ST_C_EV   = 4'd6;
   localparam logic [3:0] ST_C_OUT  = 4'd7;

   localparam logic [1:0] LAST_BYTE = 2'(slcp_pkg::CARD_ID_BYTES - 1);

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [1:0] byte_cnt_ff;
   logic [1:0] byte_cnt_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in    = state_ff;
      byte_cnt_in = byte_cnt_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!sts.line_end) begin
                  cmd.store_wr = 1'b1;
               end else if (sts.fill_nz) begin
                  priority if (sts.is_key) begin
                     cmd.pos_key  = 1'b1;
                     cmd.pend_clr = 1'b1;
                     state_in     = ST_K_RD;
                  end else if (sts.is_card) begin
                     cmd.pos_card = 1'b1;
                     cmd.id_clr   = 1'b1;
                     byte_cnt_in  = '0;
                     state_in     = ST_C_RD0;
                  end else begin
                     cmd.fill_clr = 1'b1;
                  end
               end
            end
         end
         ST_K_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_off = slcp_pkg::RD_OFF_FIRST;
            state_in   = ST_K_EV;
         end
         ST_K_EV: begin
            if (sts.rd_end) begin
               if (!sts.out_busy) begin
                  if (sts.pend_valid) begin
                     cmd.out_key  = 1'b1;
                     cmd.out_last = 1'b1;
                  end else begin
                     cmd.out_empty = 1'b1;
                  end
                  cmd.fill_clr = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (!sts.pend_valid) begin
               cmd.pend_load = 1'b1;
               cmd.pos_inc   = 1'b1;
               state_in      = ST_K_RD;
            end else if (!sts.out_busy) begin
               cmd.out_key   = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.pos_inc   = 1'b1;
               state_in      = ST_K_RD;
            end
         end
         ST_C_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_off = slcp_pkg::RD_OFF_FIRST;
            state_in   = ST_C_RD1;
         end
         ST_C_RD1: begin
            cmd.c0_cap = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_off = slcp_pkg::RD_OFF_SECOND;
            state_in   = ST_C_RD2;
         end
         ST_C_RD2: begin
            cmd.c1_cap = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_off = slcp_pkg::RD_OFF_SEP;
            state_in   = ST_C_EV;
         end
         ST_C_EV: begin
            cmd.card_step = 1'b1;
            byte_cnt_in   = byte_cnt_ff + 2'd1;
            state_in      = (byte_cnt_ff == LAST_BYTE) ? ST_C_OUT : ST_C_RD0;
         end
         ST_C_OUT: begin
            if (!sts.out_busy) begin
               cmd.out_card = 1'b1;
               cmd.fill_clr = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         byte_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

endmodule

// ----- design/serial_line_command_parser.sv -----
// serial line command parser
// input channel req_*: one received character per item in req_tdata[7:0]
// result channel rsp_*: tdata holds key_char and card_id, tuser holds
// line_kind and char_present, tlast marks the final result of a line
// ordinary characters are stored and the parser stays ready for the next
// one; CR or LF closes a non-empty line
// a "KEY " line gives one result per payload character, each from one
// store read and one evaluate step, or one empty result
// a "CARD " line gives one result: four id bytes, each read as three
// store reads and one evaluate step, then the output step
// the line store has one write and one read port and is read at most once
// per cycle; input is not taken while a line is being parsed
// results sit in one output register; a stalled receiver holds the parser
// in place, and after the last result of a line new input is taken even
// while that result still waits
// reset empties the line store and drops any pending result
module serial_line_command_parser #(
   parameter int unsigned LINE_BUFFER_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // key_char, card_id
   output logic [1:0]  rsp_tuser,   // line_kind, char_present
   output logic        rsp_tlast    // last_of_run
);

   slcp_pkg::cmd_type    cmd;
   slcp_pkg::status_type sts;

   slcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   slcp_dp #(
      .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_card_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[7:0] == 8'd0 && !rsp_tuser[1] && rsp_tlast)
      else $error("card result carries a key character");

   a_key_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[39:8] == 32'd0)
      else $error("key result carries a card id");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] && !rsp_tuser[1] |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("empty key result not final");

endmodule

// ----- sim/slcp_result_checker.sv -----
`timescale 1ns / 100ps

module slcp_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // key_char, card_id
   input  logic [1:0]  rsp_tuser,   // line_kind, char_present
   input  logic        rsp_tlast,   // last_of_run
   output int unsigned mismatches,
   output int unsigned pending_count,
   output int unsigned results_checked,
   output int unsigned cards_checked
);

   localparam int LINE_BYTES = 64;

   typedef struct packed {
      logic        kind;
      logic [7:0]  key_char;
      logic        present;
      logic [31:0] card_id;
      logic        last;
   } line_result_type;

   logic [7:0]      line_mem [0:LINE_BYTES-1];
   int              line_len;
   line_result_type expected_results [$];

   initial begin
      mismatches      = 0;
      pending_count   = 0;
      results_checked = 0;
      cards_checked   = 0;
      line_len        = 0;
   end

   // characters past the end of the line read as zero
   function automatic logic [7:0] line_char(input int idx);
      return (idx < line_len) ? line_mem[idx] : slcp_pkg::CHAR_NUL;
   endfunction

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // two characters read as a base-16 number, kept to 8 bits; after a leading blank or sign only the second is a digit
   function automatic logic [7:0] pair_value(input logic [7:0] c0, input logic [7:0] c1);
      int         v0;
      int         v1;
      logic [7:0] res;
      v0  = hex_digit(c0);
      v1  = hex_digit(c1);
      res = 8'h00;
      if (c0 == slcp_pkg::CHAR_SPACE || c0 == slcp_pkg::CHAR_TAB ||
          c0 == slcp_pkg::CHAR_LF || c0 == slcp_pkg::CHAR_VT ||
          c0 == slcp_pkg::CHAR_FF || c0 == slcp_pkg::CHAR_CR) begin
         if (v1 >= 0) res = 8'(v1);
      end else if (c0 == slcp_pkg::CHAR_PLUS || c0 == slcp_pkg::CHAR_MINUS) begin
         if (v1 >= 0) res = (c0 == slcp_pkg::CHAR_MINUS) ? 8'(256 - v1) : 8'(v1);
      end else if (v0 >= 0) begin
         res = (v1 < 0) ? 8'(v0) : 8'(v0 * 16 + v1);
      end
      return res;
   endfunction

   task automatic accept_char(input logic [7:0] c);
      line_result_type r;
      int              i;
      int              pos;
      logic [31:0]     id;
      if (c == slcp_pkg::CHAR_LF || c == slcp_pkg::CHAR_CR) begin
         if (line_len > 0) begin
            if (line_len >= slcp_pkg::KEY_PREFIX_LEN &&
                {line_mem[0], line_mem[1], line_mem[2], line_mem[3]}
                == slcp_pkg::KEY_PREFIX) begin
               r = '0;
               r.kind = slcp_pkg::KIND_KEY;
               if (line_len == slcp_pkg::KEY_PREFIX_LEN ||
                   line_mem[slcp_pkg::KEY_PREFIX_LEN] == slcp_pkg::CHAR_NUL) begin
                  r.last = 1'b1;
                  expected_results.push_back(r);
               end else begin
                  i = slcp_pkg::KEY_PREFIX_LEN;
                  while (i < line_len && line_mem[i] != slcp_pkg::CHAR_NUL) begin
                     r.key_char = line_mem[i];
                     r.present  = 1'b1;
                     r.last     = (i + 1 >= line_len) ||
                                  (line_mem[i+1] == slcp_pkg::CHAR_NUL);
                     expected_results.push_back(r);
                     i++;
                  end
               end
            end else if (line_len >= slcp_pkg::CARD_PREFIX_LEN &&
                         {line_mem[0], line_mem[1], line_mem[2], line_mem[3], line_mem[4]}
                         == slcp_pkg::CARD_PREFIX) begin
               pos = slcp_pkg::CARD_PREFIX_LEN;
               id  = '0;
               for (i = 0; i < slcp_pkg::CARD_ID_BYTES; i++) begin
                  id  = {id[23:0], pair_value(line_char(pos), line_char(pos + 1))};
                  pos = pos + 2;
                  if (line_char(pos) == slcp_pkg::CHAR_SPACE) pos++;
               end
               r         = '0;
               r.kind    = slcp_pkg::KIND_CARD;
               r.card_id = id;
               r.last    = 1'b1;
               expected_results.push_back(r);
            end
            line_len = 0;
         end
      end else if (line_len < LINE_BYTES - 1) begin
         line_mem[line_len] = c;
         line_len++;
      end else begin
         // full store: line is dropped along with this character
         line_len = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [39:0] want,
                                  input logic [39:0] got);
      $display("mismatch at result %0d (t=%0t): %s expected %h got %h",
               results_checked, $time, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      line_result_type exp_r;
      if (reset) begin
         line_len = 0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready) accept_char(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item, tdata", '0, rsp_tdata);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_tuser[0] !== exp_r.kind)
                  report_mismatch("line_kind", 40'(exp_r.kind), 40'(rsp_tuser[0]));
               if (rsp_tuser[1] !== exp_r.present)
                  report_mismatch("char_present", 40'(exp_r.present), 40'(rsp_tuser[1]));
               if (rsp_tdata[7:0] !== exp_r.key_char)
                  report_mismatch("key_char", 40'(exp_r.key_char), 40'(rsp_tdata[7:0]));
               if (rsp_tdata[39:8] !== exp_r.card_id)
                  report_mismatch("card_id", 40'(exp_r.card_id), 40'(rsp_tdata[39:8]));
               if (rsp_tlast !== exp_r.last)
                  report_mismatch("last_of_run", 40'(exp_r.last), 40'(rsp_tlast));
               if (exp_r.kind == slcp_pkg::KIND_CARD) cards_checked++;
            end
            results_checked++;
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // key_char, card_id
   logic [1:0]  rsp_tuser;   // line_kind, char_present
   logic        rsp_tlast;   // last_of_run

   int unsigned mismatches;
   int unsigned pending_count;
   int unsigned results_checked;
   int unsigned cards_checked;

   int send_idle;
   int recv_idle;
   int hold_req;
   int hold_left;
   int chars_sent;
   int lines_closed;

   serial_line_command_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   slcp_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatches      (mismatches),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .cards_checked   (cards_checked)
   );

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      rsp_tready   = 1'b0;
      send_idle    = 14;
      recv_idle    = 57;
      hold_req     = 0;
      hold_left    = 0;
      chars_sent   = 0;
      lines_closed = 0;
   end

   always #6 clock = ~clock;

   // receiver: random stalls plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_req  = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [7:0] any_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      while (c == slcp_pkg::CHAR_LF || c == slcp_pkg::CHAR_CR) c = 8'($urandom_range(255));
      return c;
   endfunction

   function automatic logic [7:0] key_char_pick();
      logic [7:0] c;
      if ($urandom_range(9) == 0) c = any_char();
      else c = 8'($urandom_range(8'h7E, 8'h21));
      return c;
   endfunction

   function automatic logic [7:0] card_char_pick();
      string      hex_set;
      logic [7:0] c;
      hex_set = "0123456789abcdefABCDEF";
      case ($urandom_range(15))
         0, 1, 2, 3, 4, 5, 6, 7: c = hex_set[$urandom_range(21)];
         8, 9:   c = slcp_pkg::CHAR_SPACE;
         10:     c = slcp_pkg::CHAR_PLUS;
         11:     c = slcp_pkg::CHAR_MINUS;
         12: begin
            case ($urandom_range(2))
               0:       c = slcp_pkg::CHAR_TAB;
               1:       c = slcp_pkg::CHAR_VT;
               default: c = slcp_pkg::CHAR_FF;
            endcase
         end
         13:     c = slcp_pkg::CHAR_NUL;
         default: c = any_char();
      endcase
      return c;
   endfunction

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      chars_sent++;
      if (c == slcp_pkg::CHAR_LF || c == slcp_pkg::CHAR_CR) lines_closed++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic random_line();
      int    pick;
      int    n;
      int    bad;
      int    i;
      string head;
      pick = $urandom_range(99);
      if (pick < 40) begin
         send_text("KEY ");
         n = ($urandom_range(7) == 0) ? $urandom_range(59) : $urandom_range(6);
         repeat (n) send_char(key_char_pick());
      end else if (pick < 70) begin
         send_text("CARD ");
         repeat ($urandom_range(12)) send_char(card_char_pick());
      end else if (pick < 84) begin
         // near miss on a prefix
         if ($urandom_range(1) != 0) head = "KEY ";
         else head = "CARD ";
         bad  = $urandom_range(head.len() - 1);
         for (i = 0; i < head.len(); i++) send_char((i == bad) ? any_char() : head[i]);
         repeat ($urandom_range(4)) send_char(key_char_pick());
      end else if (pick < 93) begin
         repeat ($urandom_range(6)) send_char(any_char());
      end else begin
         // longest run or store overflow
         send_text("KEY ");
         n = $urandom_range(1) ? $urandom_range(60, 59) : $urandom_range(70, 50);
         repeat (n) send_char(key_char_pick());
      end
      send_char($urandom_range(1) ? slcp_pkg::CHAR_LF : slcp_pkg::CHAR_CR);
      if ($urandom_range(7) == 0)
         send_char($urandom_range(1) ? slcp_pkg::CHAR_LF : slcp_pkg::CHAR_CR);
   endtask

   initial begin
      int phase;
      int phase_stop;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed lines
      send_char(slcp_pkg::CHAR_LF);
      send_char(slcp_pkg::CHAR_CR);
      send_text("KEY \n");
      send_text("KEY A");
      send_char(slcp_pkg::CHAR_NUL);
      send_text("z");
      send_char(slcp_pkg::CHAR_CR);
      send_text("CARD 12 34 56 78\n");
      send_text("CARD 0aBcFf9E");
      send_char(slcp_pkg::CHAR_CR);
      send_text("CARD 7\n");
      send_text("CARD -1+f\tc");
      send_char(slcp_pkg::CHAR_VT);
      send_text("gz\n");
      send_text("CARD  5");
      send_char(slcp_pkg::CHAR_FF);
      send_text("x\n");
      send_text("KEY \377~\001\n");
      send_text("KEY\nCARD\nxKEY q\n");
      send_char(slcp_pkg::CHAR_NUL);
      send_text("KEY q\n");
      wait_drained();

      // receiver holds off while a full-length key line and more follow
      hold_req = 1;
      send_text("KEY ");
      repeat (59) send_char(8'($urandom_range(8'h7E, 8'h21)));
      send_char(slcp_pkg::CHAR_LF);
      send_text("CARD 01020304\n");
      send_text("KEY ");
      repeat (60) send_char(8'($urandom_range(8'h7E, 8'h21)));
      send_text("KEY z\n");
      wait_drained();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 14;
               recv_idle = 57;
            end
            1: begin
               send_idle = 57;
               recv_idle = 14;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         phase_stop = chars_sent + 60;
         while (chars_sent < phase_stop) random_line();
         wait_drained();
      end

      repeat (80) @(negedge clock);
      $display("sent %0d characters closing %0d lines (empty, key, card, malformed, overflow)",
               chars_sent, lines_closed);
      $display("checked %0d result items, %0d of them card ids, under three stall mixes",
               results_checked, cards_checked);
      if (mismatches == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
